// ===== rtl/core/wtd_pkg.sv =====
// Shared constants, state encoding and control structs of the tree diameter unit.
package wtd_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int VTX_W        = 10;
	localparam int CNT_W        = 11;
	localparam int COST_W       = 16;
	localparam int DIST_W       = 26;
	localparam int EDGE_CAP     = MAX_VERTICES - 1;
	localparam int EDGE_W       = 2 * VTX_W + COST_W;
	localparam int DENT_W       = DIST_W + 1;
	localparam int STACK_W      = 2 * VTX_W;
	localparam logic [CNT_W-1:0] VC_RESET = CNT_W'(MAX_VERTICES);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_INIT,
		ST_SCAN_J,
		ST_EDGE,
		ST_DIST,
		ST_POP_W,
		ST_POP_D,
		ST_VSCAN,
		ST_VEND,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic store_edge;
		logic clr_edges;
		logic idx_clr;
		logic clr_write;
		logic sweep_init;
		logic sel_second;
		logic edge_skip;
		logic dist_rd_w;
		logic push;
		logic pop_rd;
		logic pop_load;
		logic pop_dist;
		logic scan_step;
		logic latch_first;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic j_end;
		logic depth_one;
		logic edge_hit;
		logic reached;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/wtd_ram.sv =====
// Generic single write port, single registered read port RAM.
module wtd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/wtd_dp.sv =====
// Datapath: edge store, distance store, walk stack and sweep registers.
module wtd_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wtd_pkg::cmd_t               cmd,
	output wtd_pkg::sts_t               sts,
	input  logic [wtd_pkg::VTX_W-1:0]   in_from,
	input  logic [wtd_pkg::VTX_W-1:0]   in_to,
	input  logic [wtd_pkg::COST_W-1:0]  in_cost,
	input  logic                        cfg_valid,
	input  logic [wtd_pkg::CNT_W-1:0]   cfg_data,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [wtd_pkg::DIST_W-1:0]  out_length,
	output logic [wtd_pkg::VTX_W-1:0]   out_first,
	output logic [wtd_pkg::VTX_W-1:0]   out_second
);

	localparam int VW = wtd_pkg::VTX_W;
	localparam int CW = wtd_pkg::CNT_W;
	localparam int DW = wtd_pkg::DIST_W;

	logic [CW-1:0] vc_q;
	logic [VW-1:0] etot_q;
	logic [VW-1:0] idx_q;
	logic [VW-1:0] cur_v_q, cur_j_q, w_q, first_q, best_v_q;
	logic [DW-1:0] cur_d_q, best_d_q;
	logic [wtd_pkg::COST_W-1:0] wcost_q;
	logic [CW-1:0] depth_q;
	logic          valid_s1;
	logic          out_valid_q;

	logic [CW-1:0] n;
	logic [VW-1:0] start;
	logic [DW-1:0] new_d;

	logic                      e_we;
	logic [wtd_pkg::EDGE_W-1:0] e_rd;
	logic [VW-1:0]             e_a, e_b, w_c;
	logic [wtd_pkg::COST_W-1:0] e_cost;

	logic                      d_we;
	logic [VW-1:0]             d_waddr, d_raddr;
	logic [wtd_pkg::DENT_W-1:0] d_wdata, d_rd;

	logic [wtd_pkg::STACK_W-1:0] s_rd;
	logic [VW-1:0]               s_waddr, s_raddr;

	// live vertex count, 0 acts as 1, clipped to capacity
	always_comb begin
		if (vc_q == '0) begin
			n = CW'(1);
		end else if (vc_q > wtd_pkg::VC_RESET) begin
			n = wtd_pkg::VC_RESET;
		end else begin
			n = vc_q;
		end
	end

	assign start  = cmd.sel_second ? first_q : '0;
	assign new_d  = cur_d_q + DW'(wcost_q);
	assign e_a    = e_rd[VW-1:0];
	assign e_b    = e_rd[2*VW-1:VW];
	assign e_cost = e_rd[wtd_pkg::EDGE_W-1:2*VW];
	assign w_c    = (e_a == cur_v_q) ? e_b : e_a;

	assign sts.idx_last  = ({1'b0, idx_q} == (n - CW'(1)));
	assign sts.j_end     = (cur_j_q >= etot_q);
	assign sts.depth_one = (depth_q == CW'(1));
	assign sts.edge_hit  = ({1'b0, e_a} < n) && ({1'b0, e_b} < n)
		&& ((e_a == cur_v_q) || (e_b == cur_v_q));
	assign sts.reached   = d_rd[DW];
	assign sts.out_free  = !out_valid_q || out_ready;

	assign e_we = cmd.store_edge && (etot_q != VW'(wtd_pkg::EDGE_CAP));

	wtd_ram #(.WIDTH(wtd_pkg::EDGE_W), .DEPTH(wtd_pkg::EDGE_CAP)) u_edge_ram (
		.clk     (clk),
		.wr_en   (e_we),
		.wr_addr (etot_q),
		.wr_data ({in_cost, in_to, in_from}),
		.rd_addr (cur_j_q),
		.rd_data (e_rd)
	);

	assign d_we = cmd.clr_write || cmd.sweep_init || cmd.push;

	always_comb begin
		if (cmd.clr_write) begin
			d_waddr = idx_q;
			d_wdata = '0;
		end else if (cmd.sweep_init) begin
			d_waddr = start;
			d_wdata = {1'b1, {DW{1'b0}}};
		end else begin
			d_waddr = w_q;
			d_wdata = {1'b1, new_d};
		end
		if (cmd.dist_rd_w) begin
			d_raddr = w_c;
		end else if (cmd.pop_load) begin
			d_raddr = s_rd[VW-1:0];
		end else begin
			d_raddr = idx_q;
		end
	end

	wtd_ram #(.WIDTH(wtd_pkg::DENT_W), .DEPTH(wtd_pkg::MAX_VERTICES)) u_dist_ram (
		.clk     (clk),
		.wr_en   (d_we),
		.wr_addr (d_waddr),
		.wr_data (d_wdata),
		.rd_addr (d_raddr),
		.rd_data (d_rd)
	);

	// stack holds the frames below the top; the top lives in cur_*_q
	assign s_waddr = VW'(depth_q - CW'(1));
	assign s_raddr = VW'(depth_q - CW'(2));

	wtd_ram #(.WIDTH(wtd_pkg::STACK_W), .DEPTH(wtd_pkg::MAX_VERTICES)) u_stack_ram (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (s_waddr),
		.wr_data ({cur_j_q + VW'(1), cur_v_q}),
		.rd_addr (s_raddr),
		.rd_data (s_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= wtd_pkg::VC_RESET;
			etot_q      <= '0;
			depth_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vc_q <= cfg_data;
			end
			if (cmd.clr_edges) begin
				etot_q <= '0;
			end else if (e_we) begin
				etot_q <= etot_q + VW'(1);
			end
			if (cmd.sweep_init) begin
				depth_q <= CW'(1);
			end else if (cmd.push) begin
				depth_q <= depth_q + CW'(1);
			end else if (cmd.pop_rd) begin
				depth_q <= depth_q - CW'(1);
			end
			valid_s1 <= cmd.scan_step;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.clr_write || cmd.scan_step) begin
			idx_q <= idx_q + VW'(1);
		end
		if (cmd.sweep_init) begin
			cur_v_q  <= start;
			cur_j_q  <= '0;
			cur_d_q  <= '0;
			best_v_q <= start;
			best_d_q <= '0;
		end else if (cmd.push) begin
			cur_v_q <= w_q;
			cur_j_q <= '0;
			cur_d_q <= new_d;
		end else if (cmd.edge_skip) begin
			cur_j_q <= cur_j_q + VW'(1);
		end else if (cmd.pop_load) begin
			cur_v_q <= s_rd[VW-1:0];
			cur_j_q <= s_rd[2*VW-1:VW];
		end else if (cmd.pop_dist) begin
			cur_d_q <= d_rd[DW-1:0];
		end
		if (cmd.dist_rd_w) begin
			w_q     <= w_c;
			wcost_q <= e_cost;
		end
		// farthest pick: idx_q runs one ahead of the read data, so scanned vertex is idx_q - 1
		if (valid_s1 && d_rd[DW] && (d_rd[DW-1:0] > best_d_q)) begin
			best_d_q <= d_rd[DW-1:0];
			best_v_q <= idx_q - VW'(1);
		end
		if (cmd.latch_first) begin
			first_q <= best_v_q;
		end
		if (cmd.out_load) begin
			out_length <= best_d_q;
			out_first  <= first_q;
			out_second <= best_v_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten while waiting");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (depth_q < wtd_pkg::VC_RESET))
		else $error("walk stack overflow");
	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |-> (depth_q > CW'(1)))
		else $error("pop of last frame");
`endif

endmodule

// ===== rtl/core/wtd_ctrl.sv =====
// Controller: sequences edge loading, clearing passes, sweeps and result hand-off.
module wtd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_compute,
	output logic           in_ready,
	input  wtd_pkg::sts_t  sts,
	output wtd_pkg::cmd_t  cmd
);

	wtd_pkg::state_t state_q, state_d;
	logic second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wtd_pkg::ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		second_d       = second_q;
		cmd            = '0;
		cmd.sel_second = second_q;
		in_ready       = (state_q == wtd_pkg::ST_IDLE);
		unique case (state_q)
			wtd_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_compute) begin
						cmd.idx_clr = 1'b1;
						second_d    = 1'b0;
						state_d     = wtd_pkg::ST_CLR;
					end else begin
						cmd.store_edge = 1'b1;
					end
				end
			end
			wtd_pkg::ST_CLR: begin
				cmd.clr_write = 1'b1;
				if (sts.idx_last) begin
					state_d = wtd_pkg::ST_INIT;
				end
			end
			wtd_pkg::ST_INIT: begin
				cmd.sweep_init = 1'b1;
				state_d        = wtd_pkg::ST_SCAN_J;
			end
			wtd_pkg::ST_SCAN_J: begin
				if (sts.j_end) begin
					if (sts.depth_one) begin
						cmd.idx_clr = 1'b1;
						state_d     = wtd_pkg::ST_VSCAN;
					end else begin
						cmd.pop_rd = 1'b1;
						state_d    = wtd_pkg::ST_POP_W;
					end
				end else begin
					state_d = wtd_pkg::ST_EDGE;
				end
			end
			wtd_pkg::ST_EDGE: begin
				if (sts.edge_hit) begin
					cmd.dist_rd_w = 1'b1;
					state_d       = wtd_pkg::ST_DIST;
				end else begin
					cmd.edge_skip = 1'b1;
					state_d       = wtd_pkg::ST_SCAN_J;
				end
			end
			wtd_pkg::ST_DIST: begin
				if (sts.reached) begin
					cmd.edge_skip = 1'b1;
				end else begin
					cmd.push = 1'b1;
				end
				state_d = wtd_pkg::ST_SCAN_J;
			end
			wtd_pkg::ST_POP_W: begin
				cmd.pop_load = 1'b1;
				state_d      = wtd_pkg::ST_POP_D;
			end
			wtd_pkg::ST_POP_D: begin
				cmd.pop_dist = 1'b1;
				state_d      = wtd_pkg::ST_SCAN_J;
			end
			wtd_pkg::ST_VSCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.idx_last) begin
					state_d = wtd_pkg::ST_VEND;
				end
			end
			wtd_pkg::ST_VEND: begin
				state_d = wtd_pkg::ST_FIN;
			end
			wtd_pkg::ST_FIN: begin
				if (second_q) begin
					state_d = wtd_pkg::ST_OUT;
				end else begin
					cmd.latch_first = 1'b1;
					cmd.idx_clr     = 1'b1;
					second_d        = 1'b1;
					state_d         = wtd_pkg::ST_CLR;
				end
			end
			wtd_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.clr_edges = 1'b1;
					state_d       = wtd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wtd_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == wtd_pkg::ST_IDLE))
		else $error("no return to idle after result");
	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push, cmd.pop_rd, cmd.edge_skip, cmd.pop_load, cmd.sweep_init}))
		else $error("conflicting walk commands");
	a_second_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_first |=> second_q)
		else $error("second sweep not flagged");
`endif

endmodule

// ===== rtl/core/weighted_tree_diameter_unit.sv =====
// Top level of the weighted tree diameter unit (double sweep).
//
// Channel   Dir  Signals                       Content
// s_axis    in   s_tvalid s_tready s_tdata s_tuser  edge beat or compute command
// m_axis    out  m_tvalid m_tready m_tdata          diameter length and both ends
// cfg       in   cfg_valid cfg_ready cfg_data       vertex_count register
//
// An edge beat is taken one per cycle while idle.
// A compute beat starts two sweeps, each: clearing the distance store, an
// init step, a depth-first walk that examines each edge in turn (looking up
// the far end on a hit, reloading a frame on each pop, with a final empty
// check), then the farthest-vertex scan. The result is loaded once the
// output register is free.
// The walk is bound by the single read port of the edge store; each stack
// frame rescans the store.
// Reset clears edge count, state and result valid; memories are not cleared.
// s_tready is low from a compute beat until its result is loaded; a held
// result waits in the output register without stalling edge loading.
module weighted_tree_diameter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // edge_from[9:0], edge_to[19:10], edge_cost[35:20], zero
	input  logic        s_tuser,   // command: 0 add edge, 1 compute
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // diameter_length[25:0], end_first[35:26], end_second[45:36], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data   // vertex_count
);

	wtd_pkg::cmd_t cmd;
	wtd_pkg::sts_t sts;

	logic [wtd_pkg::DIST_W-1:0] length;
	logic [wtd_pkg::VTX_W-1:0]  end_first, end_second;

	assign cfg_ready = 1'b1;

	wtd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_compute (s_tuser),
		.in_ready   (s_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	wtd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_from    (s_tdata[9:0]),
		.in_to      (s_tdata[19:10]),
		.in_cost    (s_tdata[35:20]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_length (length),
		.out_first  (end_first),
		.out_second (end_second)
	);

	assign m_tdata = {2'b00, end_second, end_first, length};

endmodule
